FILE: hdl/scp_pkg.sv
`default_nettype none
// scp_pkg: widths, opcode values, Horner divisor tables and the cell payload
// type of the sine/cosine polynomial block. Depends on nothing.
package scp_pkg;

	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;
	localparam int WORD_W = 32;
	localparam int WORK_BITS = 30;
	localparam int ANGLE_FRAC_BITS_DEF = 24;
	localparam int OUT_FRAC_BITS_DEF = 30;
	localparam int N_CELLS = 4;
	localparam int DIV_W = 7;

	// pi/4 as a decimal fraction; multiples of pi/4 are PI_NUM * k / PI_DEN
	localparam logic [63:0] PI_NUM = 64'd31415926;
	localparam logic [63:0] PI_DEN = 64'd40000000;

	localparam logic OP_SINE = 1'b0;
	localparam logic OP_COSINE = 1'b1;

	localparam logic signed [WORD_W-1:0] WORK_ONE = 32'sd1 <<< WORK_BITS;

	// one Horner step in flight: x2 is the squared angle, t the running term
	typedef struct packed {
		logic cos_sel;
		logic neg;
		logic signed [WORD_W-1:0] x;
		logic [WORD_W-1:0] x2;
		logic signed [WORD_W-1:0] t;
	} horner_t;

	// divisors of the sine series, innermost term first
	function automatic logic [DIV_W-1:0] sin_div(input int idx);
		case (idx)
			0: return 7'd72;
			1: return 7'd42;
			2: return 7'd20;
			3: return 7'd6;
			default: return 7'd1;
		endcase
	endfunction

	// divisors of the cosine series, innermost term first
	function automatic logic [DIV_W-1:0] cos_div(input int idx);
		case (idx)
			0: return 7'd56;
			1: return 7'd30;
			2: return 7'd12;
			3: return 7'd2;
			default: return 7'd1;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: hdl/scp_if.sv
`default_nettype none
// Request and result channels of the sine/cosine polynomial block.
// Depends on scp_pkg for field widths.
interface scp_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [scp_pkg::ANGLE_W-1:0] angle;

	modport source(output valid, output opcode, output angle, input ready);
	modport sink(input valid, input opcode, input angle, output ready);
endinterface

interface scp_out_if;
	logic valid;
	logic ready;
	logic signed [scp_pkg::VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: hdl/scp_reduce.sv
`default_nettype none
// scp_reduce: nine-stage range reduction of the angle to [-pi/2, pi/4] in Q30
// and squaring, feeding the first Horner cell. Depends on scp_pkg.
module scp_reduce #(
	parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire up_valid,
	output logic up_ready,
	input wire opcode,
	input wire logic signed [scp_pkg::ANGLE_W-1:0] angle,
	output logic dn_valid,
	input wire dn_ready,
	output scp_pkg::horner_t dn
);
	localparam int WW = scp_pkg::WORD_W;
	localparam int WB = scp_pkg::WORK_BITS;
	localparam int DEPTH = 9;
	localparam int XSH = WB - ANGLE_FRAC_BITS;
	localparam logic [63:0] SCALE = 64'd1 << ANGLE_FRAC_BITS;
	localparam logic [63:0] ROUND_PI = scp_pkg::PI_DEN / 64'd2;
	localparam logic [63:0] TWO_PI_L =
		(scp_pkg::PI_NUM * 64'd8 * SCALE + ROUND_PI) / scp_pkg::PI_DEN;
	localparam logic [63:0] PI_L = (scp_pkg::PI_NUM * 64'd4 * SCALE + ROUND_PI) / scp_pkg::PI_DEN;
	localparam logic [63:0] HALF_PI_L =
		(scp_pkg::PI_NUM * 64'd2 * SCALE + ROUND_PI) / scp_pkg::PI_DEN;
	localparam logic [63:0] QUARTER_PI_L = (scp_pkg::PI_NUM * SCALE + ROUND_PI) / scp_pkg::PI_DEN;
	localparam logic [WW-1:0] TWO_PI_W = TWO_PI_L[WW-1:0];
	localparam logic [WW-1:0] RECIP = WW'((64'd1 << WW) / TWO_PI_L);
	localparam logic signed [WW:0] S_TWO_PI = $signed(TWO_PI_L[WW:0]);
	localparam logic signed [WW:0] S_PI = $signed(PI_L[WW:0]);
	localparam logic signed [WW:0] S_HALF_PI = $signed(HALF_PI_L[WW:0]);
	localparam logic signed [WW:0] S_QUARTER_PI = $signed(QUARTER_PI_L[WW:0]);
	localparam logic signed [2*WW-1:0] HALF_LSB = (2*WW)'(1) <<< (WB - 1);

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH:0] adv;
	logic [DEPTH-1:0] vin;

	logic [WW-1:0] abs_in;
	logic [2*WW-1:0] recip_mul;
	logic [WW-1:0] rem_fix;
	logic signed [WW:0] a4_ext, a5_ext, a6_ext;
	logic signed [WW:0] wrap_a, fold_a, quart_a, x_ext;
	logic swap;
	logic signed [2*WW-1:0] x_wide, sq_rnd;

	logic op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic signed [WW-1:0] ang_s1, ang_s2, ang_s3;
	logic [WW-1:0] abs_s1, abs_s2;
	logic big_s1, big_s2, big_s3;
	logic [WW-1:0] qe_s2;
	logic [WW-1:0] rem_s3;
	logic signed [WW-1:0] a_s4, a_s5, a_s6;
	logic neg_s6, neg_s7, neg_s8, neg_s9;
	logic signed [WW-1:0] x_s7, x_s8, x_s9;
	logic cos_s7, cos_s8, cos_s9;
	logic signed [2*WW-1:0] sq_s8;
	logic [WW-1:0] x2_s9;

	// advance a stage when it is empty or its content moves on
	assign adv[DEPTH] = dn_ready;
	for (genvar g = 0; g < DEPTH; g++) begin : g_adv
		assign adv[g] = !vld_q[g] || adv[g+1];
	end
	assign vin = {vld_q[DEPTH-2:0], up_valid};
	assign up_ready = adv[0];
	assign dn_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	// take the magnitude and flag angles beyond a whole turn
	assign abs_in = angle[WW-1] ? $unsigned(-angle) : $unsigned(angle);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			op_s1 <= opcode;
			ang_s1 <= angle;
			abs_s1 <= abs_in;
			big_s1 <= abs_in > TWO_PI_W;
		end
	end

	// estimate the turn count with the reciprocal; low by at most one
	assign recip_mul = {{WW{1'b0}}, abs_s1} * {{WW{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s2 <= op_s1;
			ang_s2 <= ang_s1;
			abs_s2 <= abs_s1;
			big_s2 <= big_s1;
			qe_s2 <= recip_mul[2*WW-1:WW];
		end
	end

	// remove the estimated turns
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			op_s3 <= op_s2;
			ang_s3 <= ang_s2;
			big_s3 <= big_s2;
			rem_s3 <= abs_s2 - qe_s2 * TWO_PI_W;
		end
	end

	// correct the estimate and restore the sign (truncation toward zero)
	assign rem_fix = (rem_s3 >= TWO_PI_W) ? rem_s3 - TWO_PI_W : rem_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			op_s4 <= op_s3;
			if (!big_s3) begin
				a_s4 <= ang_s3;
			end else if (ang_s3[WW-1]) begin
				a_s4 <= -$signed(rem_fix);
			end else begin
				a_s4 <= $signed(rem_fix);
			end
		end
	end

	// wrap into [-pi, pi]
	assign a4_ext = (WW+1)'(a_s4);
	always_comb begin
		if (a4_ext > S_PI) begin
			wrap_a = a4_ext - S_TWO_PI;
		end else if (a4_ext < -S_PI) begin
			wrap_a = a4_ext + S_TWO_PI;
		end else begin
			wrap_a = a4_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			op_s5 <= op_s4;
			a_s5 <= wrap_a[WW-1:0];
		end
	end

	// fold by pi into [-pi/2, pi/2], flipping the sign
	assign a5_ext = (WW+1)'(a_s5);
	always_comb begin
		if (a5_ext > S_HALF_PI) begin
			fold_a = a5_ext - S_PI;
		end else if (a5_ext < -S_HALF_PI) begin
			fold_a = a5_ext + S_PI;
		end else begin
			fold_a = a5_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			op_s6 <= op_s5;
			a_s6 <= fold_a[WW-1:0];
			neg_s6 <= (a5_ext > S_HALF_PI) || (a5_ext < -S_HALF_PI);
		end
	end

	// above pi/4 switch to the complementary series on pi/2 minus the angle
	assign a6_ext = (WW+1)'(a_s6);
	assign swap = a6_ext > S_QUARTER_PI;
	assign quart_a = swap ? S_HALF_PI - a6_ext : a6_ext;
	assign x_ext = quart_a <<< XSH;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			neg_s7 <= neg_s6;
			x_s7 <= x_ext[WW-1:0];
			cos_s7 <= (op_s6 == scp_pkg::OP_COSINE) ^ swap;
		end
	end

	// square the Q30 angle
	assign x_wide = (2*WW)'(x_s7);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			neg_s8 <= neg_s7;
			x_s8 <= x_s7;
			cos_s8 <= cos_s7;
			sq_s8 <= x_wide * x_wide;
		end
	end

	// round the square half up back to Q30
	assign sq_rnd = sq_s8 + HALF_LSB;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			neg_s9 <= neg_s8;
			x_s9 <= x_s8;
			cos_s9 <= cos_s8;
			x2_s9 <= sq_rnd[WB+WW-1:WB];
		end
	end

	always_comb begin
		dn.cos_sel = cos_s9;
		dn.neg = neg_s9;
		dn.x = x_s9;
		dn.x2 = x2_s9;
		dn.t = scp_pkg::WORK_ONE;
	end

endmodule
`default_nettype wire

FILE: hdl/scp_horner_cell.sv
`default_nettype none
// scp_horner_cell: one Horner step t' = 1 - round(x2 * t) / k over four
// stages, k picked per request from the sine or cosine table. Depends on scp_pkg.
module scp_horner_cell #(
	parameter int CELL_IDX = 0
) (
	input wire clk,
	input wire arst_n,
	input wire up_valid,
	output logic up_ready,
	input wire scp_pkg::horner_t up,
	output logic dn_valid,
	input wire dn_ready,
	output scp_pkg::horner_t dn
);
	localparam int WW = scp_pkg::WORD_W;
	localparam int WB = scp_pkg::WORK_BITS;
	localparam int PW = 2 * WW - 1;
	localparam int DEPTH = 4;
	localparam logic [scp_pkg::DIV_W-1:0] K_SIN = scp_pkg::sin_div(CELL_IDX);
	localparam logic [scp_pkg::DIV_W-1:0] K_COS = scp_pkg::cos_div(CELL_IDX);
	localparam logic [WW-1:0] R_SIN = WW'((64'd1 << WW) / 64'(K_SIN));
	localparam logic [WW-1:0] R_COS = WW'((64'd1 << WW) / 64'(K_COS));
	localparam logic [PW-1:0] HALF_LSB = PW'(1) << (WB - 1);

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH:0] adv;
	logic [DEPTH-1:0] vin;

	logic [PW-1:0] prod_rnd;
	logic [WW-1:0] recip;
	logic [2*WW-1:0] recip_mul;
	logic [WW-1:0] div_k, kq, rem, quo;
	scp_pkg::horner_t ctx_nxt;

	scp_pkg::horner_t ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [PW-1:0] prod_s1;
	logic [WW-1:0] p_s2, p_s3;
	logic [WW-1:0] qe_s3;

	// advance a stage when it is empty or its content moves on
	assign adv[DEPTH] = dn_ready;
	for (genvar g = 0; g < DEPTH; g++) begin : g_adv
		assign adv[g] = !vld_q[g] || adv[g+1];
	end
	assign vin = {vld_q[DEPTH-2:0], up_valid};
	assign up_ready = adv[0];
	assign dn_valid = vld_q[DEPTH-1];
	assign dn = ctx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	// multiply the square by the running term; t is never negative here
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ctx_s1 <= up;
			prod_s1 <= PW'(up.x2) * PW'(up.t[WW-2:0]);
		end
	end

	// round half up back to Q30
	assign prod_rnd = prod_s1 + HALF_LSB;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctx_s2 <= ctx_s1;
			p_s2 <= prod_rnd[WB+WW-1:WB];
		end
	end

	// estimate the quotient by the divisor's reciprocal
	assign recip = ctx_s2.cos_sel ? R_COS : R_SIN;
	assign recip_mul = {{WW{1'b0}}, p_s2} * {{WW{1'b0}}, recip};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			ctx_s3 <= ctx_s2;
			p_s3 <= p_s2;
			qe_s3 <= recip_mul[2*WW-1:WW];
		end
	end

	// correct the estimate by one where the remainder reaches the divisor
	assign div_k = WW'(ctx_s3.cos_sel ? K_COS : K_SIN);
	assign kq = qe_s3 * div_k;
	assign rem = p_s3 - kq;
	assign quo = qe_s3 + WW'(rem >= div_k);

	// replace the running term, pass the rest of the request on
	always_comb begin
		ctx_nxt = ctx_s3;
		ctx_nxt.t = scp_pkg::WORK_ONE - $signed(quo);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			ctx_s4 <= ctx_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/scp_finish.sv
`default_nettype none
// scp_finish: final multiply by x for the sine series, fold sign, rounding to
// the output format and clamping; holds the output register. Depends on scp_pkg.
module scp_finish #(
	parameter int OUT_FRAC_BITS = scp_pkg::OUT_FRAC_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire up_valid,
	output logic up_ready,
	input wire scp_pkg::horner_t up,
	output logic dn_valid,
	input wire dn_ready,
	output logic signed [scp_pkg::VALUE_W-1:0] value
);
	localparam int WW = scp_pkg::WORD_W;
	localparam int WB = scp_pkg::WORK_BITS;
	localparam int RW = WW + 2;
	localparam int DEPTH = 3;
	localparam int SH = WB - OUT_FRAC_BITS;
	localparam logic signed [2*WW-1:0] HALF_LSB = (2*WW)'(1) <<< (WB - 1);
	localparam logic signed [RW-1:0] OUT_HALF = (RW'(1) <<< SH) >>> 1;
	localparam logic signed [RW-1:0] LIM = RW'(1) <<< OUT_FRAC_BITS;

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH:0] adv;
	logic [DEPTH-1:0] vin;

	logic signed [2*WW-1:0] prod_rnd, prod_sh;
	logic signed [WW:0] res;
	logic signed [RW-1:0] rr, rr_sh, clamped;

	scp_pkg::horner_t ctx_s1;
	logic signed [2*WW-1:0] pr_s1;
	logic signed [WW:0] r_s2;
	logic signed [WW-1:0] value_s3;

	// advance a stage when it is empty or its content moves on
	assign adv[DEPTH] = dn_ready;
	for (genvar g = 0; g < DEPTH; g++) begin : g_adv
		assign adv[g] = !vld_q[g] || adv[g+1];
	end
	assign vin = {vld_q[DEPTH-2:0], up_valid};
	assign up_ready = adv[0];
	assign dn_valid = vld_q[DEPTH-1];
	assign value = value_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	// multiply by x; only the sine series uses it
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ctx_s1 <= up;
			pr_s1 <= (2*WW)'(up.x) * (2*WW)'(up.t);
		end
	end

	// pick the series result and apply the fold sign in Q30
	assign prod_rnd = pr_s1 + HALF_LSB;
	assign prod_sh = prod_rnd >>> WB;
	assign res = ctx_s1.cos_sel ? (WW+1)'(ctx_s1.t) : prod_sh[WW:0];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			r_s2 <= ctx_s1.neg ? -res : res;
		end
	end

	// round half up to the output format and clamp to plus or minus one
	assign rr = RW'(r_s2) + OUT_HALF;
	assign rr_sh = rr >>> SH;
	always_comb begin
		if (rr_sh > LIM) begin
			clamped = LIM;
		end else if (rr_sh < -LIM) begin
			clamped = -LIM;
		end else begin
			clamped = rr_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			value_s3 <= clamped[WW-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sine_cosine_polynomial.sv
`default_nettype none
// sine_cosine_polynomial: top level; range reduction, a row of four Horner
// cells and the finishing stage. Depends on scp_pkg, scp_if and the scp_* modules.
//
// Usage: requests arrive on operand (opcode 0 for sine, 1 for cosine, angle in
// radians with ANGLE_FRAC_BITS fraction bits); results leave on result (value
// with OUT_FRAC_BITS fraction bits, within plus or minus one). Both channels
// move a request at a clock edge where valid and ready are high.
// Throughput: one request per clock while result.ready is high, with no link between requests.
// Pipeline: a request passes 28 register stages: nine for reduction and
// squaring, four in each Horner cell and three for the final product,
// rounding and the output register.
// Reset clears every stage valid bit; operand.ready is then high until the stages fill.
// When the receiver stalls, the result holds in the output register and the
// stages behind it close up their bubbles, so requests are still taken until
// every stage is full; then operand.ready drops until result.ready returns.
module sine_cosine_polynomial #(
	parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = scp_pkg::OUT_FRAC_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	scp_in_if.sink operand,
	scp_out_if.source result
);
	localparam int NC = scp_pkg::N_CELLS;

	wire [NC:0] chain_valid;
	wire [NC:0] chain_ready;
	wire scp_pkg::horner_t chain_data [NC+1];

	// reduce the angle and square it
	scp_reduce #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(operand.valid),
		.up_ready(operand.ready),
		.opcode(operand.opcode),
		.angle(operand.angle),
		.dn_valid(chain_valid[0]),
		.dn_ready(chain_ready[0]),
		.dn(chain_data[0])
	);

	// row of Horner cells, innermost term first
	for (genvar i = 0; i < NC; i++) begin : g_cell
		scp_horner_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(chain_valid[i]),
			.up_ready(chain_ready[i]),
			.up(chain_data[i]),
			.dn_valid(chain_valid[i+1]),
			.dn_ready(chain_ready[i+1]),
			.dn(chain_data[i+1])
		);
	end

	// final product, sign, rounding and output register
	scp_finish #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(chain_valid[NC]),
		.up_ready(chain_ready[NC]),
		.up(chain_data[NC]),
		.dn_valid(result.valid),
		.dn_ready(result.ready),
		.value(result.value)
	);

endmodule
`default_nettype wire

FILE: hdl/scp_checker.sv
`default_nettype none
// scp_checker: port-level checks of the sine/cosine polynomial block, bound
// to the top level below. Depends on nothing beyond the top level's ports.
module scp_checker #(
	parameter int OUT_FRAC_BITS = 30
) (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire logic signed [31:0] out_value
);
	localparam logic signed [31:0] LIM = 32'sd1 <<< OUT_FRAC_BITS;

	logic [5:0] outstanding_q;

	// count requests taken and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 6'(in_valid && in_ready)
				- 6'(out_valid && out_ready);
		end
	end

	// an idle output never holds back the input
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused while no result is waiting");

	// no result without a request in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outstanding_q != 6'd0))
		else $error("result shown with no request outstanding");

	// result stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_value <= LIM && out_value >= -LIM))
		else $error("result outside the clamp range");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("stalled result dropped or changed");

endmodule

bind sine_cosine_polynomial scp_checker #(
	.OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_scp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(operand.valid),
	.in_ready(operand.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_value(result.value)
);
`default_nettype wire
